[hw/rtl/natl2w_pkg.sv]
// Shared types and constants for the LAN-to-WAN NAT source port translator.
// Used by natl2w_ctrl, natl2w_dp and nat_lan_to_wan_translator; depends on nothing.
`default_nettype none
package natl2w_pkg;

  localparam int BUCKETS = 1024;
  localparam int WAYS    = 6;

  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int FILL_W  = $clog2(WAYS + 1);

  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int HASH_W  = 32;
  localparam int KEY_W   = ADDR_W + PORT_W;
  localparam int NEXT_W  = PORT_W + 1;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [ADDR_W-1:0] WAN_RESET   = 32'h36EF1C55;
  localparam logic [NEXT_W-1:0] FIRST_RESET = 17'd1024;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WAN_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_PORT  = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [PORT_W-1:0] port;
  } way_t;

  // One bucket is one memory row: its fill count and all of its ways.
  typedef struct packed {
    logic [FILL_W-1:0]  fill;
    way_t [WAYS-1:0]    way;
  } row_t;

  typedef struct packed {
    logic             load;       // capture the flow and read its bucket
    logic             lookup;     // compare, write back and emit the result
    logic             clear;      // zero one bucket row
    logic [BKT_W-1:0] clear_idx;
  } dp_cmd_t;

endpackage
`default_nettype wire

[hw/rtl/natl2w_ctrl.sv]
// Controller for the NAT translator: clearing pass after reset, then
// a two-state accept/lookup sequence per flow. Depends on natl2w_pkg.
`default_nettype none
module natl2w_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  output natl2w_pkg::dp_cmd_t    cmd
);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_LOOKUP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [natl2w_pkg::BKT_W-1:0] clr_cnt;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == natl2w_pkg::BKT_W'(natl2w_pkg::BUCKETS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  assign busy          = (state != S_IDLE);
  assign cmd.load      = (state == S_IDLE) && start;
  assign cmd.lookup    = (state == S_LOOKUP);
  assign cmd.clear     = (state == S_CLEAR);
  assign cmd.clear_idx = clr_cnt;

endmodule
`default_nettype wire

[hw/rtl/natl2w_dp.sv]
// Datapath for the NAT translator: bucket memory, key compare across the
// ways, port allocation counter, configuration and result registers.
// Depends on natl2w_pkg.
`default_nettype none
module natl2w_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire natl2w_pkg::dp_cmd_t                 cmd,
  input  wire logic                                cfg_we,
  input  wire logic [natl2w_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [natl2w_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic [natl2w_pkg::ADDR_W-1:0]       src_addr,
  input  wire logic [natl2w_pkg::PORT_W-1:0]       src_port,
  input  wire logic [natl2w_pkg::HASH_W-1:0]       flow_hash,
  output logic                                     done,
  output logic [natl2w_pkg::ADDR_W-1:0]            new_src_addr,
  output logic [natl2w_pkg::PORT_W-1:0]            new_src_port,
  output logic                                     hit,
  output logic                                     bucket_full,
  output logic                                     pool_exhausted
);

  natl2w_pkg::row_t mem [natl2w_pkg::BUCKETS];
  natl2w_pkg::row_t rd_row;
  natl2w_pkg::row_t wr_row;

  logic [natl2w_pkg::KEY_W-1:0]  key_q;
  logic [natl2w_pkg::BKT_W-1:0]  bkt_q;
  logic [natl2w_pkg::ADDR_W-1:0] wan_address;
  logic [natl2w_pkg::NEXT_W-1:0] next_port;

  logic [natl2w_pkg::FILL_W-1:0] fill;
  logic                          found;
  logic [natl2w_pkg::PORT_W-1:0] found_port;
  logic                          exhausted;
  logic                          room;
  logic                          alloc;
  logic                          wr_en;

  // Lookup: the lowest valid way whose key matches wins.
  always_comb begin
    fill = rd_row.fill;
    if (fill > natl2w_pkg::FILL_W'(natl2w_pkg::WAYS)) begin
      fill = natl2w_pkg::FILL_W'(natl2w_pkg::WAYS);
    end
    found      = 1'b0;
    found_port = '0;
    for (int w = natl2w_pkg::WAYS - 1; w >= 0; w--) begin
      if ((natl2w_pkg::FILL_W'(w) < fill) && (rd_row.way[w].key == key_q)) begin
        found      = 1'b1;
        found_port = rd_row.way[w].port;
      end
    end
    // The counter is past 65535 exactly when its top bit is set.
    exhausted = next_port[natl2w_pkg::NEXT_W-1];
    room      = fill < natl2w_pkg::FILL_W'(natl2w_pkg::WAYS);
    alloc     = !found && !exhausted;
    wr_en     = cmd.lookup && alloc && room;

    wr_row      = rd_row;
    wr_row.fill = fill + 1'b1;
    for (int w = 0; w < natl2w_pkg::WAYS; w++) begin
      if (natl2w_pkg::FILL_W'(w) == fill) begin
        wr_row.way[w].key  = key_q;
        wr_row.way[w].port = next_port[natl2w_pkg::PORT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[cmd.clear_idx] <= '0;
    end else if (wr_en) begin
      mem[bkt_q] <= wr_row;
    end
    if (cmd.load) begin
      rd_row <= mem[flow_hash[natl2w_pkg::BKT_W-1:0]];
      key_q  <= {src_addr, src_port};
      bkt_q  <= flow_hash[natl2w_pkg::BKT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wan_address <= natl2w_pkg::WAN_RESET;
      next_port   <= natl2w_pkg::FIRST_RESET;
    end else begin
      if (cfg_we && (cfg_index == natl2w_pkg::REG_WAN_ADDRESS)) begin
        wan_address <= cfg_data[natl2w_pkg::ADDR_W-1:0];
      end
      if (cfg_we && (cfg_index == natl2w_pkg::REG_FIRST_PORT)) begin
        next_port <= {1'b0, cfg_data[natl2w_pkg::PORT_W-1:0]};
      end else if (cmd.lookup && alloc) begin
        next_port <= next_port + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.lookup;
    end
    if (cmd.lookup) begin
      new_src_addr   <= wan_address;
      hit            <= found;
      bucket_full    <= alloc && !room;
      pool_exhausted <= !found && exhausted;
      if (found) begin
        new_src_port <= found_port;
      end else if (exhausted) begin
        new_src_port <= '0;
      end else begin
        new_src_port <= next_port[natl2w_pkg::PORT_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/nat_lan_to_wan_translator.sv]
// Top level of the LAN-to-WAN NAT source port translator.
// Instantiates natl2w_ctrl and natl2w_dp; depends on natl2w_pkg.
//
//   Channel   Handshake         Signals
//   --------  ----------------  ------------------------------------------------
//   input     start & !busy     src_addr, src_port, flow_hash
//   result    done (1 cycle)    new_src_addr, new_src_port, hit, bucket_full,
//                               pool_exhausted
//   config    cfg_we            cfg_index, cfg_data
//
// Each flow first reads its bucket row from the single-port bucket memory,
// then compares the ways and writes the row back. No new beat is accepted
// while busy is high during a lookup; done rises the cycle after the lookup.
// After reset a clearing pass zeroes all 1024 bucket rows, one per cycle;
// busy stays high until the pass ends. The receiver cannot stall: each
// result beat is shown for exactly one cycle.
`default_nettype none
module nat_lan_to_wan_translator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [natl2w_pkg::ADDR_W-1:0]     src_addr,
  input  wire logic [natl2w_pkg::PORT_W-1:0]     src_port,
  input  wire logic [natl2w_pkg::HASH_W-1:0]     flow_hash,
  output logic                                   done,
  output logic [natl2w_pkg::ADDR_W-1:0]          new_src_addr,
  output logic [natl2w_pkg::PORT_W-1:0]          new_src_port,
  output logic                                   hit,
  output logic                                   bucket_full,
  output logic                                   pool_exhausted,
  input  wire logic                              cfg_we,
  input  wire logic [natl2w_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [natl2w_pkg::CFG_W-1:0]      cfg_data
);

  natl2w_pkg::dp_cmd_t cmd;

  natl2w_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  natl2w_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .src_addr       (src_addr),
    .src_port       (src_port),
    .flow_hash      (flow_hash),
    .done           (done),
    .new_src_addr   (new_src_addr),
    .new_src_port   (new_src_port),
    .hit            (hit),
    .bucket_full    (bucket_full),
    .pool_exhausted (pool_exhausted)
  );

endmodule
`default_nettype wire
